// ----- rtl/pee_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Postfix evaluator package
// Shared types, character codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package pee_pkg;

    // Operand width: 8-bit two's complement
    localparam int unsigned VALUE_W = 8;

    // ASCII codes recognised by the evaluator
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_DIVZERO   = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_LOAD,
        S_DIV,
        S_FINISH
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    latch;        // capture the input request
        logic    push;         // push the digit value
        logic    read_lhs;     // read the left operand from the stack
        logic    write_result; // replace the two operands with the result
        logic    div_start;    // launch the divider
        logic    set_err;      // record an error (first one sticks)
        status_t err_code;
        logic    emit;         // load the result register, clear the stack
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic is_digit;
        logic is_op;
        logic is_div;
        logic last;
        logic full;       // stack holds STACK_DEPTH entries
        logic few;        // fewer than two entries
        logic rhs_zero;   // top of stack is zero
        logic div_done;
        logic out_busy;   // result register occupied and not taken
    } dp_stat_t;

endpackage

// ----- rtl/pee_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Postfix evaluator divider
// Signed 8-bit restoring divider, one quotient bit per cycle, truncating
// toward zero. The quotient wraps, so -128 / -1 gives -128.
// ----------------------------------------------------------------------------
module pee_div
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [pee_pkg::VALUE_W-1:0] dividend,
    input  logic signed [pee_pkg::VALUE_W-1:0] divisor,
    output logic                              done,
    output logic        [pee_pkg::VALUE_W-1:0] quotient
);
    import pee_pkg::*;

    localparam int unsigned STEP_W = $clog2(VALUE_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [VALUE_W-1:0]  rem_reg, rem_next;
    logic [VALUE_W-1:0]  quo_reg, quo_next;
    logic [VALUE_W-1:0]  dsr_reg, dsr_next;
    logic                neg_reg, neg_next;
    logic [VALUE_W:0]    rem_shift;
    logic [VALUE_W:0]    rem_diff;

    // Shift in the next dividend bit and trial-subtract the divisor
    assign rem_shift = {rem_reg, quo_reg[VALUE_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend[VALUE_W-1] ? VALUE_W'(-dividend) : dividend;
            dsr_next  = divisor[VALUE_W-1] ? VALUE_W'(-divisor) : divisor;
            neg_next  = dividend[VALUE_W-1] ^ divisor[VALUE_W-1];
        end
        else if (busy_reg)
        begin
            if (!rem_diff[VALUE_W])
            begin
                rem_next = rem_diff[VALUE_W-1:0];
                quo_next = {quo_reg[VALUE_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[VALUE_W-1:0];
                quo_next = {quo_reg[VALUE_W-2:0], 1'b0};
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(VALUE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Advance the working registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? VALUE_W'(-quo_reg) : quo_reg;

endmodule

// ----- rtl/pee_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Postfix evaluator datapath
// Operand stack memory, top-of-stack copy, arithmetic unit, sticky error
// and the result register.
// ----------------------------------------------------------------------------
module pee_datapath
#(
    parameter int unsigned STACK_DEPTH = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic        [7:0]                  symbol,
    input  logic                               last,
    input  logic                               out_ready,
    input  pee_pkg::ctrl_cmd_t                 cmd,
    output pee_pkg::dp_stat_t                  stat,
    output logic signed [pee_pkg::VALUE_W-1:0] value,
    output logic        [1:0]                  status,
    output logic                               out_valid
);
    import pee_pkg::*;

    localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);
    localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);

    logic [VALUE_W-1:0] stack_mem [STACK_DEPTH];

    logic [7:0]         sym_reg;
    logic               last_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    status_t            err_reg, err_next;
    logic [VALUE_W-1:0] top_reg;
    logic [VALUE_W-1:0] lhs_reg;
    logic [VALUE_W-1:0] value_reg;
    status_t            status_reg;
    logic               out_valid_reg, out_valid_next;

    logic               is_digit, is_div;
    logic [VALUE_W-1:0] digit_val;
    logic [ADDR_W-1:0]  below_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic               wr_en;
    logic [VALUE_W-1:0] alu_res;
    logic [VALUE_W-1:0] product;
    logic [VALUE_W-1:0] quotient;
    logic               div_done;

    // Decode the held character
    assign is_digit  = (sym_reg >= CHAR_ZERO) && (sym_reg <= CHAR_NINE);
    assign is_div    = (sym_reg == CHAR_SLASH);
    assign digit_val = sym_reg - CHAR_ZERO;

    // Entry below the top: left operand and result slot
    assign below_addr = count_reg[ADDR_W-1:0] - ADDR_W'(2);

    // Result of + - * / (the low byte of the product wraps the same
    // way for signed and unsigned operands)
    assign product = lhs_reg * top_reg;
    always_comb
    begin
        priority if (sym_reg == CHAR_PLUS)
            alu_res = lhs_reg + top_reg;
        else if (sym_reg == CHAR_MINUS)
            alu_res = lhs_reg - top_reg;
        else if (is_div)
            alu_res = quotient;
        else
            alu_res = product;
    end

    pee_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (lhs_reg),
        .divisor  (top_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Stack write port
    assign wr_en   = cmd.push || cmd.write_result;
    assign wr_addr = cmd.push ? count_reg[ADDR_W-1:0] : below_addr;
    assign wr_data = cmd.push ? digit_val : alu_res;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            stack_mem[wr_addr] <= wr_data;
        if (cmd.read_lhs)
            lhs_reg <= stack_mem[below_addr];
    end

    // Count, sticky error and result valid
    always_comb
    begin
        count_next     = count_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.push)
            count_next = count_reg + CNT_W'(1);
        if (cmd.write_result)
            count_next = count_reg - CNT_W'(1);
        if (cmd.set_err && (err_reg == ST_OK))
            err_next = cmd.err_code;
        if (cmd.emit)
        begin
            count_next     = '0;
            err_next       = ST_OK;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the request, the top-of-stack copy and the result payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            sym_reg  <= symbol;
            last_reg <= last;
        end
        if (wr_en)
            top_reg <= wr_data;
        if (cmd.emit)
        begin
            if (count_reg == '0)
            begin
                value_reg  <= '0;
                status_reg <= (err_reg == ST_OK) ? ST_UNDERFLOW : err_reg;
            end
            else
            begin
                value_reg  <= top_reg;
                status_reg <= err_reg;
            end
        end
    end

    assign stat.is_digit = is_digit;
    assign stat.is_op    = (sym_reg == CHAR_PLUS) || (sym_reg == CHAR_MINUS) ||
                           (sym_reg == CHAR_STAR) || is_div;
    assign stat.is_div   = is_div;
    assign stat.last     = last_reg;
    assign stat.full     = (count_reg == CNT_W'(STACK_DEPTH));
    assign stat.few      = (count_reg < CNT_W'(2));
    assign stat.rhs_zero = (top_reg == '0);
    assign stat.div_done = div_done;
    assign stat.out_busy = out_valid_reg && !out_ready;

    assign value     = value_reg;
    assign status    = status_reg;
    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/pee_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Postfix evaluator controller
// Sequences each character through decode, operand load, arithmetic and
// the end-of-expression result.
// ----------------------------------------------------------------------------
module pee_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pee_pkg::dp_stat_t  stat,
    output pee_pkg::ctrl_cmd_t cmd
);
    import pee_pkg::*;

    state_t state_reg, state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.err_code = ST_OK;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_FINISH;
                if (stat.is_digit)
                begin
                    if (stat.full)
                    begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = ST_OVERFLOW;
                    end
                    else
                        cmd.push = 1'b1;
                end
                else if (stat.is_op)
                begin
                    if (stat.few)
                    begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = ST_UNDERFLOW;
                    end
                    else if (stat.is_div && stat.rhs_zero)
                    begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = ST_DIVZERO;
                    end
                    else
                    begin
                        cmd.read_lhs = 1'b1;
                        state_next   = S_LOAD;
                    end
                end
            end
            S_LOAD:
            begin
                if (stat.is_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    cmd.write_result = 1'b1;
                    state_next       = S_FINISH;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.write_result = 1'b1;
                    state_next       = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!stat.last)
                    state_next = S_IDLE;
                else if (!stat.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

// ----- rtl/postfix_expression_evaluator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Postfix expression evaluator, top level
// Evaluates a reverse Polish expression fed one ASCII character per request.
// ----------------------------------------------------------------------------
// Digits are pushed, + - * / combine the two top entries (division truncates
// toward zero, all values are 8-bit two's complement and wrap), other
// characters are ignored. The request marked last yields one result: the top
// of stack and the first error of the expression (underflow, divide by zero,
// overflow); the stack and error are then cleared. One request is handled at
// a time: a digit or ignored character passes through decode and finish, + -
// and * also pass through operand load (one stack read of the left operand,
// the right one is kept in a register), and / also waits on the one-bit-per-
// cycle divider. A last request waits in its finish state only while the
// result register still holds a result that has not been taken.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_top
#(
    parameter int unsigned STACK_DEPTH = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic        [7:0]                  symbol,
    input  logic                               last,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [pee_pkg::VALUE_W-1:0] value,
    output logic        [1:0]                  status
);
    import pee_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    pee_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pee_datapath
    #(
        .STACK_DEPTH (STACK_DEPTH)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .symbol    (symbol),
        .last      (last),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat),
        .value     (value),
        .status    (status),
        .out_valid (out_valid)
    );

endmodule
